>>> rtl/mpsn_pkg.sv
package mpsn_pkg;

   // Walk phase of the byte parser
   typedef enum logic [1:0] {
      PHASE_PACK  = 2'd0,
      PHASE_STUFF = 2'd1,
      PHASE_PES   = 2'd2,
      PHASE_SKIP  = 2'd3
   } phase_type;

   // Start codes and stream ids
   localparam logic [7:0] PACK_CODE      = 8'hBA;
   localparam logic [7:0] END_CODE       = 8'hB9;
   localparam logic [7:0] MPEG1_BAD_ID   = 8'hBC;
   localparam logic [7:0] MPEG1_BAD_BASE = 8'hF0;
   localparam logic [7:0] MPEG2_BAD_ID0  = 8'hFC;
   localparam logic [7:0] MPEG2_BAD_ID1  = 8'hFD;
   localparam logic [7:0] MPEG2_BAD_ID2  = 8'hFE;

   // Header byte positions
   localparam logic [3:0] POS_VERSION    = 4'd4;
   localparam logic [3:0] POS_MPEG1_LAST = 4'd11;
   localparam logic [3:0] POS_MPEG2_LAST = 4'd13;
   localparam logic [3:0] POS_PACK_LIMIT = 4'd14;
   localparam logic [3:0] POS_PES_ID     = 4'd3;
   localparam logic [3:0] POS_PES_LENHI  = 4'd4;
   localparam logic [3:0] POS_PES_LIMIT  = 4'd6;

   // Buffer length at or below which the answer is a reject
   localparam logic [3:0] MIN_BYTES      = 4'd14;
   localparam logic [3:0] SEEN_MAX       = 4'd15;

   // Version codes
   localparam logic VER_MPEG1 = 1'b0;
   localparam logic VER_MPEG2 = 1'b1;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  pos;
      logic        version;
      logic [2:0]  stuff;
      logic [15:0] skip;
      logic [7:0]  len_hi;
      logic        pending;
      logic        locked;
      logic        verdict;
      logic [3:0]  seen;
   } sniff_state_type;

   localparam sniff_state_type STATE_RESET = '{
      phase:   PHASE_PACK,
      pos:     4'd0,
      version: VER_MPEG1,
      stuff:   3'd0,
      skip:    16'd0,
      len_hi:  8'd0,
      pending: 1'b0,
      locked:  1'b0,
      verdict: 1'b0,
      seen:    4'd0
   };

endpackage

>>> rtl/mpeg_program_stream_sniffer.sv
// MPEG program stream sniffer.
// Feed the buffer under test one byte per beat on the req_ channel
// (req_data_byte, with req_last_byte high on the final byte). Bytes other
// than the last produce nothing; the last byte produces one rsp_ beat whose
// rsp_is_program_stream is 1 when the buffer looks like an MPEG-1 or MPEG-2
// program stream and 0 otherwise. Buffers of 14 bytes or fewer are rejected.
// Each byte is parsed in the cycle it is accepted and the answer sits in an
// output register: it is valid in the cycle after the last byte is taken.
// Throughput is one byte per cycle while no result is held back, set by the single parser state update.
// The next buffer may start on the byte right after a last byte.
// A result waiting in the output register blocks every input byte only while
// rsp_ready is low; a result taken in the same cycle does not block input.
// Synchronous reset clears the parser to the start of a buffer and empties
// the output register.
module mpeg_program_stream_sniffer import mpsn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_program_stream
);

   sniff_state_type state_ff;
   sniff_state_type state_in;
   logic            verdict_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_data_ff;
   logic            req_take;

   mpsn_step u_step (
      .cur_state (state_ff),
      .data_byte (req_data_byte),
      .nxt_state (state_in),
      .verdict   (verdict_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // Advance the parser; restart it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_take) begin
         state_ff <= req_last_byte ? STATE_RESET : state_in;
      end
   end

   // Hold the result beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_take && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_last_byte) begin
         rsp_data_ff <= verdict_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_program_stream = rsp_data_ff;

endmodule

>>> rtl/mpsn_step.sv
module mpsn_step import mpsn_pkg::*; (
   input  sniff_state_type cur_state,
   input  logic [7:0]      data_byte,
   output sniff_state_type nxt_state,
   output logic            verdict
);

   logic       ver_eff;
   logic       pack_ok;
   logic       id_bad;
   logic [2:0] stuff_dec;
   logic [15:0] skip_dec;
   logic [15:0] pes_len;

   // Resolve the version seen in this byte, then the pack byte check
   always_comb begin
      ver_eff = cur_state.version;
      if (cur_state.pos == POS_VERSION && !cur_state.pending) begin
         if (data_byte[7:6] == 2'b00) begin
            ver_eff = VER_MPEG1;
         end else if (data_byte[7:6] == 2'b01) begin
            ver_eff = VER_MPEG2;
         end
      end
      case (cur_state.pos)
         4'd0, 4'd1: pack_ok = (data_byte == 8'h00);
         4'd2:       pack_ok = (data_byte == 8'h01);
         4'd3:       pack_ok = (data_byte == PACK_CODE);
         4'd4: begin
            if (data_byte[7:6] == 2'b00) begin
               pack_ok = (data_byte[5:4] == 2'b10) && data_byte[0];
            end else if (data_byte[7:6] == 2'b01) begin
               pack_ok = data_byte[2];
            end else begin
               pack_ok = 1'b0;
            end
         end
         4'd6, 4'd8: pack_ok = ver_eff ? data_byte[2] : data_byte[0];
         4'd9:       pack_ok = ver_eff ? data_byte[0] : data_byte[7];
         4'd11:      pack_ok = ver_eff ? 1'b1 : data_byte[0];
         4'd12:      pack_ok = ver_eff ? (data_byte[1:0] == 2'b11) : 1'b1;
         default:    pack_ok = 1'b1;
      endcase
   end

   // Stream ids that do not belong to the version in force
   always_comb begin
      if (cur_state.version == VER_MPEG1) begin
         id_bad = (data_byte == MPEG1_BAD_ID) || (data_byte >= MPEG1_BAD_BASE);
      end else begin
         id_bad = (data_byte == MPEG2_BAD_ID0) || (data_byte == MPEG2_BAD_ID1)
               || (data_byte == MPEG2_BAD_ID2);
      end
   end

   assign stuff_dec = cur_state.stuff - 3'd1;
   assign skip_dec  = cur_state.skip - 16'd1;
   assign pes_len   = {cur_state.len_hi, data_byte};

   // Next state
   always_comb begin
      nxt_state = cur_state;
      if (cur_state.seen != SEEN_MAX) begin
         nxt_state.seen = cur_state.seen + 4'd1;
      end
      if (!cur_state.locked) begin
         case (cur_state.phase)
            PHASE_PACK: begin
               nxt_state.version = ver_eff;
               if (!cur_state.pending && pack_ok && cur_state.pos == POS_MPEG1_LAST
                     && ver_eff == VER_MPEG1) begin
                  nxt_state.phase = PHASE_PES;
                  nxt_state.pos   = 4'd0;
               end else if (!cur_state.pending && pack_ok
                     && cur_state.pos == POS_MPEG2_LAST && ver_eff == VER_MPEG2) begin
                  nxt_state.stuff = data_byte[2:0];
                  nxt_state.pos   = 4'd0;
                  nxt_state.phase = (data_byte[2:0] != 3'd0) ? PHASE_STUFF : PHASE_PES;
               end else begin
                  nxt_state.pending = cur_state.pending || !pack_ok;
                  if (nxt_state.pending && cur_state.pos >= POS_PACK_LIMIT) begin
                     nxt_state.locked  = 1'b1;
                     nxt_state.verdict = 1'b0;
                  end else begin
                     nxt_state.pos = cur_state.pos + 4'd1;
                  end
               end
            end
            PHASE_PES: begin
               if (cur_state.pending) begin
                  if (cur_state.pos >= POS_PES_LIMIT) begin
                     nxt_state.locked  = 1'b1;
                     nxt_state.verdict = 1'b0;
                  end else begin
                     nxt_state.pos = cur_state.pos + 4'd1;
                  end
               end else if (cur_state.pos < POS_PES_ID) begin
                  // Prefix bytes 00 00 01; a miss re-reads the unit as a pack
                  if (data_byte != ((cur_state.pos == 4'd2) ? 8'h01 : 8'h00)) begin
                     nxt_state.phase   = PHASE_PACK;
                     nxt_state.pending = 1'b1;
                  end
                  nxt_state.pos = cur_state.pos + 4'd1;
               end else if (cur_state.pos == POS_PES_ID) begin
                  nxt_state.pos = POS_PES_LENHI;
                  if (id_bad) begin
                     nxt_state.pending = 1'b1;
                  end else if (data_byte == PACK_CODE) begin
                     nxt_state.phase = PHASE_PACK;
                  end else if (data_byte == END_CODE) begin
                     nxt_state.pos     = cur_state.pos;
                     nxt_state.locked  = 1'b1;
                     nxt_state.verdict = 1'b1;
                  end
               end else if (cur_state.pos == POS_PES_LENHI) begin
                  nxt_state.len_hi = data_byte;
                  nxt_state.pos    = cur_state.pos + 4'd1;
               end else if (pes_len == 16'd0) begin
                  nxt_state.pending = 1'b1;
                  nxt_state.pos     = POS_PES_LIMIT;
               end else begin
                  nxt_state.skip  = pes_len;
                  nxt_state.phase = PHASE_SKIP;
                  nxt_state.pos   = 4'd0;
               end
            end
            PHASE_STUFF: begin
               nxt_state.stuff = stuff_dec;
               if (stuff_dec == 3'd0) begin
                  nxt_state.phase = PHASE_PES;
                  nxt_state.pos   = 4'd0;
               end
            end
            PHASE_SKIP: begin
               nxt_state.skip = skip_dec;
               if (skip_dec == 16'd0) begin
                  nxt_state.phase = PHASE_PES;
                  nxt_state.pos   = 4'd0;
               end
            end
            default: begin
               nxt_state = cur_state;
            end
         endcase
      end
   end

   // Answer for a buffer that ends on this byte
   always_comb begin
      if (nxt_state.seen <= MIN_BYTES) begin
         verdict = 1'b0;
      end else if (nxt_state.locked) begin
         verdict = nxt_state.verdict;
      end else begin
         verdict = 1'b1;
      end
   end

endmodule

>>> bench/mpeg_program_stream_sniffer_test.sv
`timescale 1ns / 100ps

import mpsn_pkg::*;

// Predict the verdict of each buffer and check the rsp_ beats against it
class verdict_scoreboard;
   sniff_state_type st;
   bit              verdicts_due[$];
   int              mismatches;

   function new();
      st = STATE_RESET;
      mismatches = 0;
   endfunction

   function int outstanding();
      return verdicts_due.size();
   endfunction

   function void settle_verdict(bit v);
      st.locked = 1'b1;
      st.verdict = v;
   endfunction

   function void enter_pes();
      st.phase = PHASE_PES;
      st.pos = 4'd0;
   endfunction

   // Check one pack header byte; the version byte also picks the layout
   function bit pack_byte_good(logic [3:0] p, logic [7:0] v);
      bit m2;
      m2 = (st.version == VER_MPEG2);
      case (p)
         4'd0, 4'd1: return v == 8'h00;
         4'd2: return v == 8'h01;
         4'd3: return v == PACK_CODE;
         POS_VERSION: begin
            if (v[7:6] == 2'b00) begin
               st.version = VER_MPEG1;
               return v[7:4] == 4'h2 && v[0];
            end
            if (v[7:6] == 2'b01) begin
               st.version = VER_MPEG2;
               return v[2];
            end
            return 1'b0;
         end
         4'd6, 4'd8: return m2 ? v[2] : v[0];
         4'd9: return m2 ? v[0] : v[7];
         4'd11: return m2 ? 1'b1 : v[0];
         4'd12: return m2 ? (v[1:0] == 2'b11) : 1'b1;
         default: return 1'b1;
      endcase
   endfunction

   function void parse_pack(logic [7:0] v);
      logic [3:0] p;
      p = st.pos;
      if (!st.pending) begin
         if (!pack_byte_good(p, v)) begin
            st.pending = 1'b1;
         end else if (p == POS_MPEG1_LAST && st.version == VER_MPEG1) begin
            enter_pes();
            return;
         end else if (p == POS_MPEG2_LAST && st.version == VER_MPEG2) begin
            st.stuff = v[2:0];
            if (st.stuff != 3'd0) begin
               st.phase = PHASE_STUFF;
               st.pos = 4'd0;
            end else begin
               enter_pes();
            end
            return;
         end
      end
      if (st.pending && p >= POS_PACK_LIMIT) begin
         settle_verdict(1'b0);
         return;
      end
      st.pos = p + 4'd1;
   endfunction

   function void parse_pes(logic [7:0] v);
      logic [3:0] p;
      bit         bad;
      p = st.pos;
      if (st.pending) begin
         if (p >= POS_PES_LIMIT) settle_verdict(1'b0);
         else st.pos = p + 4'd1;
         return;
      end
      if (p < POS_PES_ID) begin
         // prefix broken: re-read this unit as a pack header
         if (v != ((p == 4'd2) ? 8'h01 : 8'h00)) begin
            st.phase = PHASE_PACK;
            st.pending = 1'b1;
         end
         st.pos = p + 4'd1;
      end else if (p == POS_PES_ID) begin
         if (st.version == VER_MPEG1)
            bad = (v == MPEG1_BAD_ID) || (v >= MPEG1_BAD_BASE);
         else
            bad = (v == MPEG2_BAD_ID0) || (v == MPEG2_BAD_ID1) || (v == MPEG2_BAD_ID2);
         if (bad) begin
            st.pending = 1'b1;
         end else if (v == PACK_CODE) begin
            st.phase = PHASE_PACK;
         end else if (v == END_CODE) begin
            settle_verdict(1'b1);
            return;
         end
         st.pos = POS_PES_LENHI;
      end else if (p == POS_PES_LENHI) begin
         st.len_hi = v;
         st.pos = POS_PES_LENHI + 4'd1;
      end else begin
         if ({st.len_hi, v} == 16'd0) begin
            st.pending = 1'b1;
            st.pos = POS_PES_LIMIT;
         end else begin
            st.skip = {st.len_hi, v};
            st.phase = PHASE_SKIP;
            st.pos = 4'd0;
         end
      end
   endfunction

   // Advance the prediction by one accepted byte
   function void note_byte(logic [7:0] v, logic last);
      bit r;
      if (st.seen < SEEN_MAX) st.seen = st.seen + 4'd1;
      if (!st.locked) begin
         case (st.phase)
            PHASE_PACK: parse_pack(v);
            PHASE_PES: parse_pes(v);
            PHASE_STUFF: begin
               st.stuff = st.stuff - 3'd1;
               if (st.stuff == 3'd0) enter_pes();
            end
            default: begin
               st.skip = st.skip - 16'd1;
               if (st.skip == 16'd0) enter_pes();
            end
         endcase
      end
      if (last) begin
         if (st.seen <= MIN_BYTES) r = 1'b0;
         else if (st.locked) r = st.verdict;
         else r = 1'b1;
         st = STATE_RESET;
         verdicts_due.push_back(r);
      end
   endfunction

   function void check_verdict(logic actual);
      bit want;
      if (verdicts_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("verdict %b arrived with none due", actual);
      end else begin
         want = verdicts_due.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("verdict mismatch: expected %b, got %b", want, actual);
         end
      end
   endfunction
endclass

module mpeg_program_stream_sniffer_test;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_program_stream;

   verdict_scoreboard sb;
   logic [7:0]        stream_q[$];
   bit                idling_on;
   int                bytes_sent;
   int                streams_sent;
   int                mark;

   mpeg_program_stream_sniffer uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_is_program_stream (rsp_is_program_stream)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the result side at random while idling is on
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = idling_on ? ($urandom_range(99) >= 22) : 1'b1;
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_verdict(rsp_is_program_stream);
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

   // Drive one byte; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (idling_on && $urandom_range(99) < 22) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_last_byte = last;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_byte(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
   endtask

   // Hold the sender until every due verdict has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Append a well-formed pack header from byte 'first' on, with its stuffing
   function automatic void put_pack_header(bit mpeg2, int first);
      logic [7:0] h[14];
      int         n;
      for (int i = 0; i < 14; i++) h[i] = 8'($urandom);
      h[0] = 8'h00;
      h[1] = 8'h00;
      h[2] = 8'h01;
      h[3] = PACK_CODE;
      if (mpeg2) begin
         h[4][7:6] = 2'b01;
         h[4][2] = 1'b1;
         h[6][2] = 1'b1;
         h[8][2] = 1'b1;
         h[9][0] = 1'b1;
         h[12][1:0] = 2'b11;
         n = 14;
      end else begin
         h[4][7:4] = 4'h2;
         h[4][0] = 1'b1;
         h[6][0] = 1'b1;
         h[8][0] = 1'b1;
         h[9][7] = 1'b1;
         h[11][0] = 1'b1;
         n = 12;
      end
      for (int i = first; i < n; i++) stream_q.push_back(h[i]);
      if (mpeg2) repeat (h[13][2:0]) stream_q.push_back(8'($urandom));
   endfunction

   // Append a PES packet; a long payload is cut, which ends the buffer
   function automatic bit put_pes(logic [7:0] id, int len);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h01);
      stream_q.push_back(id);
      stream_q.push_back(8'(len >> 8));
      stream_q.push_back(8'(len));
      repeat ((len > 200) ? 200 : len) stream_q.push_back(8'($urandom));
      return len > 200;
   endfunction

   function automatic logic [7:0] legal_id(bit mpeg2);
      logic [7:0] v;
      bit         bad;
      do begin
         v = 8'($urandom);
         if (mpeg2)
            bad = (v == MPEG2_BAD_ID0) || (v == MPEG2_BAD_ID1) || (v == MPEG2_BAD_ID2);
         else
            bad = (v == MPEG1_BAD_ID) || (v >= MPEG1_BAD_BASE);
      end while (bad || v == PACK_CODE || v == END_CODE);
      return v;
   endfunction

   function automatic logic [7:0] illegal_id(bit mpeg2);
      if (mpeg2) return MPEG2_BAD_ID0 + 8'($urandom_range(2));
      if ($urandom_range(1)) return MPEG1_BAD_ID;
      return MPEG1_BAD_BASE + 8'($urandom_range(15));
   endfunction

   function automatic void push_code(logic [7:0] code);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h01);
      stream_q.push_back(code);
   endfunction

   // Mostly well-formed streams with random content, some noise and damage
   function automatic void build_random_stream();
      int kind;
      int units;
      int r;
      int len;
      int cut;
      bit mpeg2;
      bit stop;
      stream_q.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
         repeat ($urandom_range(1, 30))
            stream_q.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
      end else begin
         mpeg2 = $urandom_range(1);
         put_pack_header(mpeg2, 0);
         stop = 1'b0;
         units = $urandom_range(0, 5);
         for (int i = 0; i < units && !stop; i++) begin
            r = $urandom_range(99);
            if (r < 65) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 12);
               stop = put_pes(legal_id(mpeg2), len);
            end else if (r < 80) begin
               mpeg2 = $urandom_range(1);
               push_code(PACK_CODE);
               put_pack_header(mpeg2, POS_VERSION);
            end else if (r < 88) begin
               stop = put_pes(legal_id(mpeg2), 0);
            end else begin
               stop = put_pes(illegal_id(mpeg2), $urandom_range(1, 8));
            end
         end
         if (!stop && $urandom_range(2) == 0) begin
            push_code(END_CODE);
            repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom));
         end
         if ($urandom_range(4) == 0)
            stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom);
         if ($urandom_range(3) == 0) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end
      end
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      idling_on = 1'b1;
      bytes_sent = 0;
      streams_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Short buffers at the byte extremes
      stream_q = '{8'h00};
      send_stream();
      stream_q = '{8'hFF};
      send_stream();

      // Program end code after an MPEG-1 pack
      stream_q.delete();
      put_pack_header(1'b0, 0);
      push_code(END_CODE);
      send_stream();

      // MPEG-2 pack with its random stuffing, one PES, end code, trailing junk
      stream_q.delete();
      put_pack_header(1'b1, 0);
      void'(put_pes(legal_id(1'b1), 3));
      push_code(END_CODE);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h00);
      send_stream();

      // Version bits neither MPEG-1 nor MPEG-2
      stream_q.delete();
      put_pack_header(1'b0, 0);
      stream_q[4] = 8'hC4;
      repeat (8) stream_q.push_back(8'($urandom));
      send_stream();

      // Zero PES length, reached and not reached
      stream_q.delete();
      put_pack_header(1'b0, 0);
      void'(put_pes(legal_id(1'b0), 0));
      repeat (3) stream_q.push_back(8'($urandom));
      send_stream();
      stream_q.delete();
      put_pack_header(1'b0, 0);
      void'(put_pes(legal_id(1'b0), 0));
      send_stream();

      // Prefix mismatch where a PES is due
      stream_q.delete();
      put_pack_header(1'b1, 0);
      push_code(8'h00);
      stream_q[stream_q.size() - 2] = 8'h02;
      repeat (14) stream_q.push_back(8'($urandom));
      send_stream();

      // New pack header in PES position, switching version
      stream_q.delete();
      put_pack_header(1'b0, 0);
      push_code(PACK_CODE);
      put_pack_header(1'b1, POS_VERSION);
      void'(put_pes(legal_id(1'b1), 2));
      push_code(END_CODE);
      send_stream();

      // Stream ids banned for each version
      stream_q.delete();
      put_pack_header(1'b0, 0);
      void'(put_pes(MPEG1_BAD_ID, 4));
      send_stream();
      stream_q.delete();
      put_pack_header(1'b1, 0);
      void'(put_pes(MPEG2_BAD_ID2, 4));
      send_stream();

      // 14 and 15 byte buffers with a truncated tail
      stream_q.delete();
      put_pack_header(1'b0, 0);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      send_stream();
      stream_q.push_back(8'h01);
      send_stream();

      wait_drained();

      // Random streams with idling, a stretch without, then idling again
      while (bytes_sent < 300) begin
         build_random_stream();
         send_stream();
      end
      wait_drained();
      idling_on = 1'b0;
      mark = bytes_sent;
      while (bytes_sent - mark < 120) begin
         build_random_stream();
         send_stream();
      end
      idling_on = 1'b1;
      while (bytes_sent < 560 || streams_sent < 25) begin
         build_random_stream();
         send_stream();
      end

      // Drain, then let stray beats show up
      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> mpeg_program_stream_sniffer.f
rtl/mpsn_pkg.sv
rtl/mpsn_step.sv
rtl/mpeg_program_stream_sniffer.sv
bench/mpeg_program_stream_sniffer_test.sv
